// ===== hdl/cst_pkg.sv =====
// shared types, constants and helpers for the c subset tokenizer
package cst_pkg;

   localparam int CounterWidthDefault = 16;
   localparam int ValueWidthDefault = 32;

   typedef enum logic [4:0] {
      TK_INT = 5'd0, TK_LPAREN = 5'd1, TK_RPAREN = 5'd2, TK_LBRACE = 5'd3,
      TK_RBRACE = 5'd4, TK_SEMI = 5'd5, TK_PLUS = 5'd6, TK_PLUS_EQ = 5'd7,
      TK_MINUS = 5'd8, TK_DEC = 5'd9, TK_STAR = 5'd10, TK_SLASH = 5'd11,
      TK_PERCENT = 5'd12, TK_COMMA = 5'd13, TK_TILDE = 5'd14, TK_IDENT = 5'd15,
      TK_TYPE = 5'd16, TK_KEYWORD = 5'd17, TK_UNKNOWN = 5'd18
   } token_kind_type;

   typedef enum logic [2:0] {
      PK_NONE = 3'd0, PK_NUM = 3'd1, PK_ID = 3'd2, PK_PLUS = 3'd3, PK_MINUS = 3'd4
   } pending_kind_type;

   typedef struct packed {
      logic [7:0] character;
      logic       end_of_text;
   } req_item_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] line_number;
      logic [15:0] column_number;
      logic [31:0] int_value;
      logic [7:0]  token_length;
      logic [7:0]  bad_glyph;
      logic        last_of_run;
   } rsp_item_type;

   // one entry carries up to two tokens of a single item
   typedef struct packed {
      logic         two;
      rsp_item_type first;
      rsp_item_type second;
   } tok_pair_type;

   function automatic logic [7:0] word_char(input logic [2:0] k, input logic [2:0] p);
      logic [7:0] w [0:7][0:5];
      w[0] = '{"v","o","i","d",8'h0,8'h0};
      w[1] = '{"c","h","a","r",8'h0,8'h0};
      w[2] = '{"s","h","o","r","t",8'h0};
      w[3] = '{"i","n","t",8'h0,8'h0,8'h0};
      w[4] = '{"l","o","n","g",8'h0,8'h0};
      w[5] = '{"f","l","o","a","t",8'h0};
      w[6] = '{"d","o","u","b","l","e"};
      w[7] = '{"r","e","t","u","r","n"};
      if (p > 3'd5) return 8'h0;
      return w[k][p];
   endfunction

   function automatic logic [7:0] word_len(input logic [2:0] k);
      unique case (k)
         3'd0, 3'd1, 3'd4: return 8'd4;
         3'd2, 3'd5: return 8'd5;
         3'd3: return 8'd3;
         default: return 8'd6;
      endcase
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

endpackage

// ===== hdl/cst_front.sv =====
// front end: scanner state, character classing and token formation
module cst_front import cst_pkg::*; #(
   parameter int COUNTER_WIDTH = CounterWidthDefault,
   parameter int VALUE_WIDTH = ValueWidthDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         q_push,
   output tok_pair_type q_data,
   input  logic         q_full
);

   localparam logic [COUNTER_WIDTH-1:0] CntMax = '1;

   logic [COUNTER_WIDTH-1:0] line_ff, line_in, col_ff, col_in, pcol_ff, pcol_in;
   pending_kind_type         pk_ff, pk_in;
   logic [VALUE_WIDTH-1:0]   val_ff, val_in;
   logic [7:0]               len_ff, len_in, mask_ff, mask_in;

   logic       take;
   logic [7:0] c;
   logic       eot;
   logic [VALUE_WIDTH-1:0] digit;
   rsp_item_type tok [0:1];
   logic [1:0] n;

   assign req_ready = !q_full;
   assign take = req_valid && req_ready;
   assign c = req_item.character;
   assign eot = req_item.end_of_text;
   assign digit = VALUE_WIDTH'(c - "0");

   function automatic logic [COUNTER_WIDTH-1:0] sat_inc(input logic [COUNTER_WIDTH-1:0] v);
      return (v == CntMax) ? v : v + 1'b1;
   endfunction

   function automatic logic [7:0] next_mask(input logic [7:0] m, input logic [7:0] p,
                                            input logic [7:0] ch);
      logic [7:0] r;
      r = m;
      for (int k = 0; k < 8; k++)
         if (!(p < word_len(3'(k)) && word_char(3'(k), p[2:0]) == ch)) r[k] = 1'b0;
      return r;
   endfunction

   function automatic logic [4:0] word_class(input logic [7:0] m, input logic [7:0] l);
      logic t;
      t = 1'b0;
      for (int k = 0; k < 7; k++)
         if (m[k] && l == word_len(3'(k))) t = 1'b1;
      if (t) return TK_TYPE;
      if (m[7] && l == word_len(3'd7)) return TK_KEYWORD;
      return TK_IDENT;
   endfunction

   function automatic rsp_item_type mk(input logic [4:0] kind, input logic [15:0] ln,
                                       input logic [15:0] cl, input logic [31:0] v,
                                       input logic [7:0] l, input logic [7:0] g);
      rsp_item_type r;
      r.token_kind = kind;
      r.line_number = ln;
      r.column_number = cl;
      r.int_value = v;
      r.token_length = l;
      r.bad_glyph = g;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   always_comb begin
      logic consumed;
      logic [15:0] ln16, pc16, cc16;
      logic [31:0] v32;
      logic [4:0]  k;
      line_in = line_ff;
      col_in = col_ff;
      pk_in = pk_ff;
      pcol_in = pcol_ff;
      val_in = val_ff;
      len_in = len_ff;
      mask_in = mask_ff;
      tok[0] = '0;
      tok[1] = '0;
      n = 2'd0;
      consumed = 1'b0;
      ln16 = 16'(line_ff);
      pc16 = 16'(pcol_ff);
      cc16 = 16'(col_ff);
      v32 = 32'(val_ff);
      k = TK_UNKNOWN;
      if (!eot && pk_ff == PK_NUM && is_digit(c)) begin
         col_in = sat_inc(col_ff);
         val_in = VALUE_WIDTH'(val_ff * VALUE_WIDTH'(10) + digit);
         if (len_ff != 8'hFF) len_in = len_ff + 8'd1;
         consumed = 1'b1;
      end else if (!eot && pk_ff == PK_ID && (is_alpha(c) || is_digit(c))) begin
         col_in = sat_inc(col_ff);
         mask_in = next_mask(mask_ff, len_ff, c);
         if (len_ff != 8'hFF) len_in = len_ff + 8'd1;
         consumed = 1'b1;
      end else if (!eot && pk_ff == PK_PLUS && c == "=") begin
         tok[0] = mk(TK_PLUS_EQ, ln16, pc16, '0, '0, '0);
         n = 2'd1;
         consumed = 1'b1;
      end else if (!eot && pk_ff == PK_MINUS && c == "-") begin
         tok[0] = mk(TK_DEC, ln16, pc16, '0, '0, '0);
         n = 2'd1;
         consumed = 1'b1;
      end else begin
         unique case (pk_ff)
            PK_NUM: begin
               tok[0] = mk(TK_INT, ln16, cc16, v32, len_ff, '0);
               n = 2'd1;
            end
            PK_ID: begin
               tok[0] = mk(word_class(mask_ff, len_ff), ln16, pc16, '0, len_ff, '0);
               n = 2'd1;
            end
            PK_PLUS: begin
               tok[0] = mk(TK_PLUS, ln16, pc16, '0, '0, '0);
               n = 2'd1;
            end
            PK_MINUS: begin
               tok[0] = mk(TK_MINUS, ln16, pc16, '0, '0, '0);
               n = 2'd1;
            end
            default: n = 2'd0;
         endcase
      end
      if (n != 2'd0 || eot) begin
         pk_in = PK_NONE;
         pcol_in = '0;
         val_in = '0;
         len_in = '0;
         mask_in = 8'hFF;
      end
      if (!eot && !consumed) begin
         col_in = sat_inc(col_ff);
         if (c == 8'h0A) begin
            line_in = sat_inc(line_ff);
            col_in = {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};
         end else if (c == 8'h0D || c == " ") begin
         end else if (is_digit(c)) begin
            pk_in = PK_NUM;
            val_in = digit;
            len_in = 8'd1;
         end else if (is_alpha(c)) begin
            pk_in = PK_ID;
            pcol_in = col_in;
            mask_in = next_mask(8'hFF, 8'd0, c);
            len_in = 8'd1;
         end else if (c == "+") begin
            pk_in = PK_PLUS;
            pcol_in = col_in;
         end else if (c == "-") begin
            pk_in = PK_MINUS;
            pcol_in = col_in;
         end else begin
            unique case (c)
               "(": k = TK_LPAREN;
               ")": k = TK_RPAREN;
               "{": k = TK_LBRACE;
               "}": k = TK_RBRACE;
               ";": k = TK_SEMI;
               "*": k = TK_STAR;
               "/": k = TK_SLASH;
               "%": k = TK_PERCENT;
               ",": k = TK_COMMA;
               "~": k = TK_TILDE;
               default: k = TK_UNKNOWN;
            endcase
            tok[n[0]] = mk(k, ln16, 16'(col_in), '0, '0, (k == TK_UNKNOWN) ? c : 8'h0);
            n = n + 2'd1;
         end
      end
   end

   always_comb begin
      q_push = take && n != 2'd0;
      q_data.two = n == 2'd2;
      q_data.first = tok[0];
      q_data.second = tok[1];
      q_data.first.last_of_run = n == 2'd1;
      q_data.second.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};
         col_ff <= {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};
         pk_ff <= PK_NONE;
         pcol_ff <= '0;
         val_ff <= '0;
         len_ff <= '0;
         mask_ff <= 8'hFF;
      end else if (take) begin
         line_ff <= line_in;
         col_ff <= col_in;
         pk_ff <= pk_in;
         pcol_ff <= pcol_in;
         val_ff <= val_in;
         len_ff <= len_in;
         mask_ff <= mask_in;
      end
   end

endmodule

// ===== hdl/cst_queue.sv =====
// small fifo of token pairs between front and back
module cst_queue import cst_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  tok_pair_type push_data,
   output logic         full,
   input  logic         pop,
   output logic         not_empty,
   output tok_pair_type head
);

   tok_pair_type mem_ff [0:3];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   assign full = cnt_ff == 3'd4;
   assign not_empty = cnt_ff != 3'd0;
   assign head = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
   end

endmodule

// ===== hdl/cst_back.sv =====
// back end: splits token pairs and drives the result register
module cst_back import cst_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  tok_pair_type q_head,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   logic         vld_ff, sel_ff, sel_in;
   rsp_item_type out_ff;
   logic         load;

   assign load = q_valid && (!vld_ff || rsp_ready);
   assign q_pop = load && (!q_head.two || sel_ff);
   assign sel_in = load ? (q_head.two && !sel_ff) : sel_ff;
   assign rsp_valid = vld_ff;
   assign rsp_item = out_ff;

   always_ff @(posedge clock) begin
      if (load) out_ff <= sel_ff ? q_head.second : q_head.first;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
         if (load) vld_ff <= 1'b1;
         else if (rsp_ready) vld_ff <= 1'b0;
      end
   end

endmodule

// ===== hdl/c_subset_tokenizer.sv =====
// top level of the c subset tokenizer
// Streaming lexer: one character item is accepted per cycle while the queue has room,
// and yields zero, one or two token items. The front end classifies each character
// combinationally and pushes the tokens it forms into a four-entry queue; the back end
// delivers one token per cycle while rsp_ready allows, through a result register, and
// the queue absorbs an item's second token. Ready drops only when the queue is full.
module c_subset_tokenizer import cst_pkg::*; #(
   parameter int COUNTER_WIDTH = CounterWidthDefault,
   parameter int VALUE_WIDTH = ValueWidthDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   logic         q_push, q_full, q_pop, q_ne;
   tok_pair_type q_data, q_head;

   cst_front #(.COUNTER_WIDTH(COUNTER_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_item,
      .q_push, .q_data, .q_full
   );

   cst_queue u_queue (
      .clock, .reset, .push(q_push), .push_data(q_data), .full(q_full),
      .pop(q_pop), .not_empty(q_ne), .head(q_head)
   );

   cst_back u_back (
      .clock, .reset, .q_valid(q_ne), .q_head, .q_pop,
      .rsp_valid, .rsp_ready, .rsp_item
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push) else $error("push into full queue");
   a_ready_tracks_queue: assert property (@(posedge clock) disable iff (reset)
      req_ready == !q_full) else $error("ready mismatch");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the c subset tokenizer: predicted tokens vs. observed
`timescale 1ns / 1ps
module testbench;
   import cst_pkg::*;

   localparam int CNT_MAX = 65535;
   localparam int ITEM_COUNT = 1950;
   localparam int CYCLE_LIMIT = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;

   c_subset_tokenizer DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item)
   );

   always #10 clock = ~clock;

   req_item_type     char_queue[$];
   rsp_item_type     token_queue[$];
   int               error_count = 0;
   int               cycle_count = 0;
   bit               quiet_phase = 1'b0;
   bit               drain_hold = 1'b0;
   int               send_gap = 0;
   int               recv_gap = 0;

   // lexer state
   int               lex_line;
   int               lex_col;
   pending_kind_type lex_pending;
   int               lex_pcol;
   logic [31:0]      lex_value;
   int               lex_len;
   logic [7:0]       lex_mask;

   function automatic string word_text(int k);
      string w[8] = '{"void", "char", "short", "int", "long", "float", "double", "return"};
      return w[k];
   endfunction

   function automatic bit digit_char(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit alpha_char(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic int bump(int v);
      return (v >= CNT_MAX) ? CNT_MAX : v + 1;
   endfunction

   task automatic push_token(token_kind_type kind, int col, logic [31:0] val,
                             int len, logic [7:0] glyph);
      rsp_item_type t;
      t.token_kind = kind;
      t.line_number = lex_line[15:0];
      t.column_number = col[15:0];
      t.int_value = val;
      t.token_length = len[7:0];
      t.bad_glyph = glyph;
      t.last_of_run = 1'b0;
      token_queue.push_back(t);
   endtask

   task automatic clear_pending();
      lex_pending = PK_NONE;
      lex_pcol = 0;
      lex_value = '0;
      lex_len = 0;
      lex_mask = 8'hFF;
   endtask

   task automatic narrow_mask(logic [7:0] c);
      string w;
      for (int k = 0; k < 8; k++) begin
         w = word_text(k);
         if (!(lex_len < w.len() && w[lex_len] == c)) lex_mask[k] = 1'b0;
      end
   endtask

   function automatic token_kind_type word_kind();
      string w;
      for (int k = 0; k < 7; k++) begin
         w = word_text(k);
         if (lex_mask[k] && lex_len == w.len()) return TK_TYPE;
      end
      if (lex_mask[7] && lex_len == 6) return TK_KEYWORD;
      return TK_IDENT;
   endfunction

   task automatic flush_pending();
      case (lex_pending)
         PK_NUM: push_token(TK_INT, lex_col, lex_value, lex_len, 8'h0);
         PK_ID: push_token(word_kind(), lex_pcol, '0, lex_len, 8'h0);
         PK_PLUS: push_token(TK_PLUS, lex_pcol, '0, 0, 8'h0);
         PK_MINUS: push_token(TK_MINUS, lex_pcol, '0, 0, 8'h0);
         default: ;
      endcase
      clear_pending();
   endtask

   task automatic lex_char(req_item_type it);
      logic [7:0] c;
      bit done;
      int prior_count;
      token_kind_type kind;
      c = it.character;
      done = 1'b0;
      prior_count = token_queue.size();
      if (it.end_of_text) begin
         flush_pending();
      end else begin
         if (lex_pending == PK_NUM && digit_char(c)) begin
            lex_col = bump(lex_col);
            lex_value = lex_value * 10 + (c - "0");
            if (lex_len < 255) lex_len++;
            done = 1'b1;
         end else if (lex_pending == PK_ID && (alpha_char(c) || digit_char(c))) begin
            lex_col = bump(lex_col);
            narrow_mask(c);
            if (lex_len < 255) lex_len++;
            done = 1'b1;
         end else if (lex_pending == PK_PLUS && c == "=") begin
            push_token(TK_PLUS_EQ, lex_pcol, '0, 0, 8'h0);
            clear_pending();
            done = 1'b1;
         end else if (lex_pending == PK_MINUS && c == "-") begin
            push_token(TK_DEC, lex_pcol, '0, 0, 8'h0);
            clear_pending();
            done = 1'b1;
         end else begin
            flush_pending();
         end
         if (!done) begin
            lex_col = bump(lex_col);
            if (c == 8'h0A) begin
               lex_line = bump(lex_line);
               lex_col = 1;
            end else if (c == 8'h0D || c == " ") begin
            end else if (digit_char(c)) begin
               lex_pending = PK_NUM;
               lex_value = c - "0";
               lex_len = 1;
            end else if (alpha_char(c)) begin
               lex_pending = PK_ID;
               lex_pcol = lex_col;
               lex_mask = 8'hFF;
               narrow_mask(c);
               lex_len = 1;
            end else if (c == "+") begin
               lex_pending = PK_PLUS;
               lex_pcol = lex_col;
            end else if (c == "-") begin
               lex_pending = PK_MINUS;
               lex_pcol = lex_col;
            end else begin
               case (c)
                  "(": kind = TK_LPAREN;
                  ")": kind = TK_RPAREN;
                  "{": kind = TK_LBRACE;
                  "}": kind = TK_RBRACE;
                  ";": kind = TK_SEMI;
                  "*": kind = TK_STAR;
                  "/": kind = TK_SLASH;
                  "%": kind = TK_PERCENT;
                  ",": kind = TK_COMMA;
                  "~": kind = TK_TILDE;
                  default: kind = TK_UNKNOWN;
               endcase
               push_token(kind, lex_col, '0, 0, kind == TK_UNKNOWN ? c : 8'h0);
            end
         end
      end
      if (token_queue.size() > prior_count)
         token_queue[token_queue.size() - 1].last_of_run = 1'b1;
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
               cycle_count);
   endtask

   task automatic add_char(logic [7:0] c);
      char_queue.push_back('{character: c, end_of_text: 1'b0});
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
   endtask

   task automatic add_end(logic [7:0] junk);
      char_queue.push_back('{character: junk, end_of_text: 1'b1});
   endtask

   function automatic string random_word();
      string s;
      int n;
      case ($urandom_range(0, 5))
         0, 1: return word_text($urandom_range(0, 7));
         2: begin
            s = word_text($urandom_range(0, 7));
            return s.substr(0, $urandom_range(0, s.len() - 2));
         end
         3: return {word_text($urandom_range(0, 7)), "x"};
         default: begin
            s = "";
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
               s = {s, string'(i > 0 && $urandom_range(0, 3) == 0 ?
                    8'($urandom_range("0", "9")) : 8'($urandom_range("a", "z")))};
            return s;
         end
      endcase
   endfunction

   function automatic string random_lexeme();
      string ops[16] = '{"(", ")", "{", "}", ";", "*", "/", "%", ",", "~", "+", "+=",
                         "-", "--", "=", "\t"};
      string s;
      case ($urandom_range(0, 9))
         0, 1, 2: return random_word();
         3, 4: begin
            s = "";
            for (int i = $urandom_range(1, 12); i > 0; i--)
               s = {s, string'(8'($urandom_range("0", "9")))};
            return s;
         end
         5, 6: return ops[$urandom_range(0, 15)];
         7: return " ";
         8: return ($urandom_range(0, 1) != 0) ? "\n" : "\r";
         default: return "";
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) void'(char_queue.pop_front());
         if ((req_valid && !req_ready)) begin
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (char_queue.size() > 0 &&
                      !(drain_hold && (token_queue.size() > 0 || req_valid))) begin
            req_valid <= 1'b1;
            req_item <= char_queue[0];
            if (!quiet_phase && $urandom_range(0, 19) == 0)
               send_gap <= $urandom_range(1, 15);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // the prediction is made when the item is accepted
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) lex_char(req_item);
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (token_queue.size() == 0) begin
            report_mismatch("unexpected item", rsp_item.token_kind, 0);
         end else begin
            want = token_queue.pop_front();
            if (rsp_item.token_kind !== want.token_kind)
               report_mismatch("token_kind", rsp_item.token_kind, want.token_kind);
            if (rsp_item.line_number !== want.line_number)
               report_mismatch("line_number", rsp_item.line_number, want.line_number);
            if (rsp_item.column_number !== want.column_number)
               report_mismatch("column_number", rsp_item.column_number,
                               want.column_number);
            if (rsp_item.int_value !== want.int_value)
               report_mismatch("int_value", rsp_item.int_value, want.int_value);
            if (rsp_item.token_length !== want.token_length)
               report_mismatch("token_length", rsp_item.token_length, want.token_length);
            if (rsp_item.bad_glyph !== want.bad_glyph)
               report_mismatch("bad_glyph", rsp_item.bad_glyph, want.bad_glyph);
            if (rsp_item.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", rsp_item.last_of_run, want.last_of_run);
         end
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!quiet_phase && $urandom_range(0, 19) == 0) recv_gap <= $urandom_range(1, 15);
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("c_subset_tokenizer regression: fail");
         $finish;
      end
   end

   initial begin
      string s;
      int target;
      lex_line = 1;
      lex_col = 1;
      clear_pending();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: every punctuator, operator pairs, words, wrap, bad bytes
      add_text("int return(){};*/%,~x+=1--a+ b- ");
      add_text("4294967296 99999999999\n");
      add_char(8'h09);
      add_char("=");
      add_char(8'hFF);
      add_char(8'h80);
      add_char(8'h00);
      add_char(8'h7F);
      add_text("voidx shor double_ Long\r");
      add_end(8'hAA);
      add_end(8'h55);
      add_text("7+");
      add_end(8'h00);
      add_char("-");
      add_end(8'hFF);

      // long tokens push length saturation
      for (int i = 0; i < 300; i++) add_char("z");
      add_char(" ");
      for (int i = 0; i < 300; i++) add_char("9");
      add_char("\n");

      // random source text, mostly well formed lexemes
      while (char_queue.size() < ITEM_COUNT - 250) begin
         if ($urandom_range(0, 19) == 0) begin
            add_char(8'($urandom_range(0, 255)));
         end else if ($urandom_range(0, 59) == 0) begin
            add_end(8'($urandom_range(0, 255)));
         end else begin
            s = random_lexeme();
            add_text(s);
         end
      end
      add_end(8'h00);

      // once under 1000 items remain, hold new items until all predicted tokens have drained
      wait (char_queue.size() < 1000);
      drain_hold = 1'b1;
      wait (token_queue.size() == 0 && !req_valid);
      drain_hold = 1'b0;

      // last section of random text
      target = char_queue.size() + 240;
      while (char_queue.size() < target) begin
         s = random_lexeme();
         add_text(s);
      end
      add_text("a b;");
      add_text("12 q;");
      add_end(8'h00);

      wait (char_queue.size() < 250);
      quiet_phase = 1'b1;

      wait (char_queue.size() == 0 && !req_valid);
      wait (token_queue.size() == 0);
      repeat (20) @(posedge clock);
      if (error_count == 0 && token_queue.size() == 0)
         $display("c_subset_tokenizer regression: pass");
      else
         $display("c_subset_tokenizer regression: fail");
      $finish;
   end
endmodule
